[design/permutation_unrank_assert.svh]
// ---------------------------------------------------------------------------
// permutation_unrank_assert.svh - assertion macros
// Clocked implication checks with a synchronous active-low reset.
// ---------------------------------------------------------------------------
`ifndef PERMUTATION_UNRANK_ASSERT_SVH
`define PERMUTATION_UNRANK_ASSERT_SVH

// Same-cycle implication.
`define PU_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PU_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/pu_pkg.sv]
// ---------------------------------------------------------------------------
// pu_pkg - permutation unrank package
// Field widths and the factorial table for the factorial number system.
// ---------------------------------------------------------------------------
`default_nettype none

package pu_pkg;

    localparam int RANK_W  = 45;   // input rank width
    localparam int FIELD_W = 4;    // position / element_value width
    localparam int CFG_W   = 5;    // perm_size register width
    localparam int FACT_W  = 64;   // holds 20!, and the weights shifted by QW-1
    localparam int FACT_IW = 5;    // index into the factorial table
    localparam int FACT_N  = 21;   // 0! .. 20!

    typedef logic [FACT_W-1:0] fact_t;

    localparam fact_t FACT_TABLE [0:FACT_N-1] = '{
        64'd1,
        64'd1,
        64'd2,
        64'd6,
        64'd24,
        64'd120,
        64'd720,
        64'd5040,
        64'd40320,
        64'd362880,
        64'd3628800,
        64'd39916800,
        64'd479001600,
        64'd6227020800,
        64'd87178291200,
        64'd1307674368000,
        64'd20922789888000,
        64'd355687428096000,
        64'd6402373705728000,
        64'd121645100408832000,
        64'd2432902008176640000
    };

endpackage

`default_nettype wire

[design/permutation_unrank.sv]
// ---------------------------------------------------------------------------
// permutation_unrank - Lehmer-code permutation unranking
// Turns a lexicographic rank into a permutation, one element per transfer.
// ---------------------------------------------------------------------------
// Usage:
//  - Input channel (s_valid/s_ready/s_rank): one rank per transfer. s_ready is
//    high only while the block is idle, so one rank is processed at a time.
//  - Result channel (m_*): one transfer per position 0..N-1, N the effective
//    perm_size (0 reads as 1, above MAX_SIZE reads as MAX_SIZE); m_last marks
//    the final one. A rank not below N! gives a single transfer with
//    m_rank_error and m_last set, position and value zero.
//  - Config channel (cfg_valid/cfg_ready/cfg_data): writes perm_size; always
//    ready, write only while no rank is in flight.
//  - Timing: a range check after the input transfer, then per position
//    restoring division into a QW-bit quotient (QW = clog2(MAX_SIZE), one
//    quotient bit per cycle on the shared compare/subtract unit) plus a pick.
//    After the last element is registered the sequencer idles and takes the
//    next rank; a rank not below N! goes from the check straight to the error
//    transfer.
//  - Reset: perm_size returns to 16, the sequencer idles, no result is held.
//  - Stall: the result register holds while m_ready is low; the division for
//    the next position proceeds and then waits in the pick cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module permutation_unrank
    import pu_pkg::*;
#(
    parameter int MAX_SIZE = 16
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // configuration
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [CFG_W-1:0]    cfg_data,
    // input ranks
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [RANK_W-1:0]   s_rank,
    // results
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [FIELD_W-1:0]       m_position,
    output logic [FIELD_W-1:0]       m_element_value,
    output logic                     m_last,
    output logic                     m_rank_error
);

`include "permutation_unrank_assert.svh"

    localparam int VW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;   // value / position / quotient
    localparam int QW = VW;
    localparam int SW = $clog2(MAX_SIZE + 1);                     // size
    localparam int KW = (QW > 1) ? $clog2(QW) : 1;                // quotient bit counter

    // sequencer codes
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_PICK  = 3'd3;
    localparam logic [2:0] ST_ERR   = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [CFG_W-1:0]  cfg_size_reg;
    logic [SW-1:0]     size_reg, size_next;
    logic [RANK_W-1:0] rem_reg, rem_next;
    fact_t             sw_reg, sw_next;       // weight shifted to current quotient bit
    logic [QW-1:0]     q_reg, q_next;
    logic [KW-1:0]     cnt_reg, cnt_next;
    logic [VW-1:0]     pos_reg, pos_next;
    logic [VW-1:0]     list_reg [MAX_SIZE];   // unused values, ascending
    logic [VW-1:0]     list_next [MAX_SIZE];

    logic                m_valid_reg, m_valid_next;
    logic [FIELD_W-1:0]  m_position_reg, m_position_next;
    logic [FIELD_W-1:0]  m_element_reg, m_element_next;
    logic                m_last_reg, m_last_next;
    logic                m_error_reg, m_error_next;

    logic          out_free;
    logic          in_xfer;
    logic [SW-1:0] eff_size;
    logic          ge;
    logic          is_last;
    logic [VW-1:0] pick;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign in_xfer   = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    assign m_valid         = m_valid_reg;
    assign m_position      = m_position_reg;
    assign m_element_value = m_element_reg;
    assign m_last          = m_last_reg;
    assign m_rank_error    = m_error_reg;

    // clamp the configured size to 1..MAX_SIZE
    always_comb begin
        if (cfg_size_reg == '0) begin
            eff_size = SW'(1);
        end else if (cfg_size_reg > CFG_W'(MAX_SIZE)) begin
            eff_size = SW'(MAX_SIZE);
        end else begin
            eff_size = SW'(cfg_size_reg);
        end
    end

    // shared compare/subtract unit
    assign ge      = (FACT_W'(rem_reg) >= sw_reg);
    assign is_last = ((SW'(pos_reg) + SW'(1)) == size_reg);
    assign pick    = list_reg[q_reg];

    always_comb begin
        state_next      = state_reg;
        size_next       = size_reg;
        rem_next        = rem_reg;
        sw_next         = sw_reg;
        q_next          = q_reg;
        cnt_next        = cnt_reg;
        pos_next        = pos_reg;
        list_next       = list_reg;
        m_valid_next    = m_valid_reg;
        m_position_next = m_position_reg;
        m_element_next  = m_element_reg;
        m_last_next     = m_last_reg;
        m_error_next    = m_error_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    rem_next   = s_rank;
                    size_next  = eff_size;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                for (int i = 0; i < MAX_SIZE; i++) begin
                    list_next[i] = VW'(i);
                end
                pos_next = '0;
                q_next   = '0;
                cnt_next = KW'(QW - 1);
                sw_next  = FACT_TABLE[FACT_IW'(size_reg - SW'(1))] << (QW - 1);
                if (FACT_W'(rem_reg) >= FACT_TABLE[FACT_IW'(size_reg)]) begin
                    state_next = ST_ERR;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (ge) begin
                    rem_next = rem_reg - sw_reg[RANK_W-1:0];
                end
                q_next  = (q_reg << 1) | QW'(ge);
                sw_next = sw_reg >> 1;
                cnt_next = cnt_reg - KW'(1);
                if (cnt_reg == '0) begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_position_next = FIELD_W'(pos_reg);
                    m_element_next  = FIELD_W'(pick);
                    m_last_next     = is_last;
                    m_error_next    = 1'b0;
                    // drop the picked value from the list
                    for (int i = 0; i < MAX_SIZE - 1; i++) begin
                        if (i >= int'(q_reg)) begin
                            list_next[i] = list_reg[i+1];
                        end
                    end
                    if (is_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        pos_next   = pos_reg + VW'(1);
                        q_next     = '0;
                        cnt_next   = KW'(QW - 1);
                        sw_next    = FACT_TABLE[FACT_IW'(size_reg - SW'(2) - SW'(pos_reg))]
                                     << (QW - 1);
                        state_next = ST_DIV;
                    end
                end
            end
            ST_ERR: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_position_next = '0;
                    m_element_next  = '0;
                    m_last_next     = 1'b1;
                    m_error_next    = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cfg_size_reg <= CFG_W'(16);
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                cfg_size_reg <= cfg_data;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        size_reg       <= size_next;
        rem_reg        <= rem_next;
        sw_reg         <= sw_next;
        q_reg          <= q_next;
        cnt_reg        <= cnt_next;
        pos_reg        <= pos_next;
        list_reg       <= list_next;
        m_position_reg <= m_position_next;
        m_element_reg  <= m_element_next;
        m_last_reg     <= m_last_next;
        m_error_reg    <= m_error_next;
    end

    // checks
    `PU_ASSERT_NOW(a_err_shape, aclk, aresetn, m_valid && m_rank_error, m_last && (m_position == '0) && (m_element_value == '0), "error result must be a lone flagged transfer")
    `PU_ASSERT_NOW(a_q_range, aclk, aresetn, state_reg == ST_PICK, (SW'(q_reg) + SW'(pos_reg)) < size_reg, "quotient exceeds remaining values")
    `PU_ASSERT_NEXT(a_div_flow, aclk, aresetn, state_reg == ST_DIV, (state_reg == ST_DIV) || (state_reg == ST_PICK), "division left early")
    `PU_ASSERT_NEXT(a_accept_check, aclk, aresetn, s_valid && s_ready, state_reg == ST_CHECK, "accepted rank not range checked")

endmodule

`default_nettype wire

[bench/tb.sv]
// ---------------------------------------------------------------------------
// tb - permutation_unrank testbench
// Drives ranks under several perm_size settings and compares every element
// transfer with an in-bench Lehmer-code predictor, under random idling and
// backpressure on both channels.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import pu_pkg::*;

    localparam int MAX_SIZE = 16;

    typedef logic [RANK_W-1:0] rank_t;

    // One element transfer as seen on the result channel.
    typedef struct packed {
        logic [FIELD_W-1:0] position;
        logic [FIELD_W-1:0] element_value;
        logic               last;
        logic               rank_error;
    } perm_elem_t;

    logic               aclk            = 1'b0;
    logic               aresetn         = 1'b0;
    logic               cfg_valid       = 1'b0;
    logic               cfg_ready;
    logic [CFG_W-1:0]   cfg_data        = '0;
    logic               s_valid         = 1'b0;
    logic               s_ready;
    rank_t              s_rank          = '0;
    logic               m_valid;
    logic               m_ready         = 1'b0;
    logic [FIELD_W-1:0] m_position;
    logic [FIELD_W-1:0] m_element_value;
    logic               m_last;
    logic               m_rank_error;

    // Expected element transfers, oldest first.
    perm_elem_t       expected_elems[$];
    logic [CFG_W-1:0] size_reg       = 5'd16;   // mirror of perm_size
    int               mismatch_count = 0;
    int unsigned      send_idle_pct  = 0;
    int unsigned      recv_stall_pct = 0;
    int unsigned      hold_request   = 0;       // long m_ready hold, in cycles
    int unsigned      hold_left      = 0;

    permutation_unrank #(
        .MAX_SIZE        (MAX_SIZE)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rank          (s_rank),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_position      (m_position),
        .m_element_value (m_element_value),
        .m_last          (m_last),
        .m_rank_error    (m_rank_error)
    );

    always #10 aclk = ~aclk;

    // -----------------------------------------------------------------------
    // Predictor
    // -----------------------------------------------------------------------
    function automatic logic [63:0] factorial(input int unsigned n);
        logic [63:0] f;
        f = 64'd1;
        for (int unsigned k = 2; k <= n; k++) begin
            f = f * k;
        end
        return f;
    endfunction

    // perm_size as the block uses it: 0 acts as 1, oversize clamps.
    function automatic int unsigned active_size();
        if (size_reg == 0) begin
            return 1;
        end
        if (size_reg > MAX_SIZE) begin
            return MAX_SIZE;
        end
        return 32'(size_reg);
    endfunction

    // Append one expected element transfer at the tail of the queue.
    function automatic void enqueue_expected(input perm_elem_t e);
        expected_elems = {expected_elems, e};
    endfunction

    // Decode one rank into its element transfers (factorial number system).
    function automatic void unrank_expected(input rank_t r);
        int unsigned   n;
        logic [63:0]   rest;
        logic [63:0]   weight;
        logic [63:0]   q;
        logic [31:0]   used;
        int unsigned   seen;
        int unsigned   pick;
        perm_elem_t    e;
        n    = active_size();
        rest = 64'(r);
        used = '0;
        if (rest >= factorial(n)) begin
            e = '{position: '0, element_value: '0, last: 1'b1, rank_error: 1'b1};
            enqueue_expected(e);
            return;
        end
        for (int unsigned p = 0; p < n; p++) begin
            weight = factorial(n - 1 - p);
            q      = rest / weight;
            rest   = rest - q * weight;
            seen   = 0;
            pick   = 0;
            // q-th unused value, counting from zero
            for (int unsigned v = 0; v < n; v++) begin
                if (!used[v]) begin
                    if (seen == q) begin
                        pick = v;
                        break;
                    end
                    seen++;
                end
            end
            used[pick] = 1'b1;
            e.position      = p[FIELD_W-1:0];
            e.element_value = pick[FIELD_W-1:0];
            e.last          = (p + 1 == n);
            e.rank_error    = 1'b0;
            enqueue_expected(e);
        end
    endfunction

    // -----------------------------------------------------------------------
    // Checking
    // -----------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin
        perm_elem_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_elems.size() == 0) begin
                report_mismatch($sformatf("transfer with nothing expected: pos %0d val %0d",
                                          m_position, m_element_value));
            end else begin
                want = expected_elems.pop_front();
                if (m_position !== want.position)
                    report_mismatch($sformatf("position %0d, expected %0d",
                                              m_position, want.position));
                if (m_element_value !== want.element_value)
                    report_mismatch($sformatf("element_value %0d, expected %0d at pos %0d",
                                              m_element_value, want.element_value,
                                              want.position));
                if (m_last !== want.last)
                    report_mismatch($sformatf("last %0b, expected %0b at pos %0d",
                                              m_last, want.last, want.position));
                if (m_rank_error !== want.rank_error)
                    report_mismatch($sformatf("rank_error %0b, expected %0b",
                                              m_rank_error, want.rank_error));
            end
        end
    end

    // -----------------------------------------------------------------------
    // Result-side flow control: random stalls, plus a long hold on request
    // -----------------------------------------------------------------------
    always @(negedge aclk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // -----------------------------------------------------------------------
    // Shared drivers
    // -----------------------------------------------------------------------
    // Offer one rank; returns at the rising edge of the transfer. s_valid is
    // left high, so back-to-back ranks keep it high unless send_idle_pct inserts idling.
    task automatic send_rank(input rank_t r);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_rank  <= r;
        do @(posedge aclk); while (!s_ready);
        unrank_expected(r);
    endtask

    // Stop sending and wait for every expected element; leaves the block idle.
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_elems.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_perm_size(input logic [CFG_W-1:0] v);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        size_reg = v;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Random rank for size n: mostly legal, some at or past n! and some raw.
    function automatic rank_t pick_rank(input int unsigned n);
        logic [63:0] lim;
        logic [63:0] raw;
        lim = factorial(n);
        raw = {$urandom, $urandom};
        case ($urandom_range(19))
            0:       return raw[RANK_W-1:0];
            1:       return lim[RANK_W-1:0];
            2:       return rank_t'(lim - 1);
            3:       return '0;
            default: return rank_t'(raw % lim);
        endcase
    endfunction

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------
    // Reset size of 16: both ends of the legal range and the error case.
    task automatic test_reset_size();
        send_rank('0);
        send_rank(rank_t'(factorial(16) - 1));
        send_rank(rank_t'(factorial(16)));
        send_rank('1);
        send_rank(rank_t'(64'd10_000_000_000_000));
        drain_results();
    endtask

    // Size 1, size 0 (read as 1) and size 2; at sizes 1 and 0 one element, anything above 0 is an error.
    task automatic test_smallest_sizes();
        write_perm_size(5'd1);
        send_rank('0);
        send_rank(rank_t'(1));
        drain_results();
        write_perm_size(5'd0);
        send_rank('0);
        send_rank(rank_t'(1));
        send_rank('1);
        drain_results();
        write_perm_size(5'd2);
        send_rank('0);
        send_rank(rank_t'(1));
        send_rank(rank_t'(2));
        drain_results();
    endtask

    // Sizes above MAX_SIZE clamp to it.
    task automatic test_oversize();
        write_perm_size(5'd31);
        send_rank(rank_t'(factorial(16) - 1));
        send_rank(rank_t'(factorial(16)));
        drain_results();
        write_perm_size(5'd17);
        send_rank(rank_t'(12345));
        send_rank(rank_t'(factorial(16) - 2));
        drain_results();
    endtask

    // Long receiver hold while ranks keep coming: the block must stall its
    // input; then a full drain with the sender paused, and four more ranks.
    task automatic test_backpressure();
        write_perm_size(5'd16);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        @(posedge aclk);
        hold_request = 300;
        for (int i = 0; i < 6; i++) begin
            send_rank(pick_rank(16));
        end
        drain_results();
        for (int i = 0; i < 4; i++) begin
            send_rank(pick_rank(active_size()));
        end
        drain_results();
    endtask

    // Idling phases crossed with several perm_size settings.
    task automatic test_random_ranks();
        int unsigned      idle_pct  [4] = '{0, 46, 0, 28};
        int unsigned      stall_pct [4] = '{0, 0, 46, 28};
        logic [CFG_W-1:0] extreme   [4] = '{5'd1, 5'd16, 5'd31, 5'd0};
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = idle_pct[ph];
            recv_stall_pct = stall_pct[ph];
            for (int s = 0; s < 4; s++) begin
                drain_results();
                write_perm_size(s == 0 ? extreme[ph] : CFG_W'($urandom_range(31)));
                for (int i = 0; i < 26; i++) begin
                    send_rank(pick_rank(active_size()));
                end
            end
        end
        drain_results();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    initial begin
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        test_reset_size();
        test_smallest_sizes();
        test_oversize();
        test_random_ranks();
        test_backpressure();

        drain_results();
        repeat (100) @(posedge aclk);
        if (mismatch_count == 0 && expected_elems.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

[filelist.f]
+incdir+design
design/pu_pkg.sv
design/permutation_unrank.sv
bench/tb.sv
